// ===== rtl/rti_pkg.sv =====
// Shared types and constants for the ray-triangle intersection pipeline.
// No dependencies; used by ray_triangle_intersect.
package rti_pkg;

    // Fixed-point format of coordinates and of the barycentric outputs.
    localparam int FRAC_BITS = 16;
    localparam int BARY_BITS = 16;

    // Datapath widths.
    localparam int EDGE_W = 33;                  // vertex difference
    localparam int CRS_W  = 67;                  // cross product component
    localparam int LO_W   = 34;                  // low slice of a cross component
    localparam int PLO_W  = EDGE_W + LO_W + 1;   // low partial product
    localparam int PHI_W  = EDGE_W + CRS_W - LO_W; // high partial product
    localparam int TERM_W = PHI_W + LO_W;        // one dot product term
    localparam int DOT_W  = TERM_W + 2;          // sum of three terms
    localparam int QT_W   = 33;                  // magnitude bits of t quotient
    localparam int QB_W   = BARY_BITS + 1;       // bits of u and v quotients
    localparam int DIV_W  = DOT_W + QT_W - 1;    // divider remainder

    // Hit threshold: 0.0001 in the scale of det.
    localparam logic signed [DOT_W-1:0] EPS =
        DOT_W'(((128'd1 << (3 * FRAC_BITS)) + 128'd5000) / 128'd10000);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } t_reg_idx;

    // One triangle request.
    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_tri_in;

    // One intersection result.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] dist_t;
        logic [16:0]        bary_u;
        logic [16:0]        bary_v;
    } t_hit_out;

endpackage

// ===== rtl/ray_triangle_intersect.sv =====
// Top level of the single-sided ray-triangle intersection pipeline.
// Depends on rti_pkg for payload types, widths and the hit threshold.
//
// Usage:
// The ray origin and direction are written through the configuration
// channel (i_cfg_valid, i_cfg_index, i_cfg_data; o_cfg_ready is always
// high) while no triangle is in flight. Triangles then stream in on the
// input channel (i_in_valid, o_in_ready, i_in) and one result per
// triangle leaves on the output channel (o_out_valid, i_out_ready, o_out).
// The pipeline has seven stages of edge, cross and dot products and hit
// test, 33 stages of a restoring divider that retires one quotient bit
// per stage, and the output register. Throughput is one triangle per
// cycle unless the receiver stalls; the 41-stage pipeline moves as a
// whole and every stage carries its own valid bit.
// When the receiver stalls with a result held in the output register, the
// whole pipeline freezes and o_in_ready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the ray registers to zero.
// A miss returns all result fields as zero.
module ray_triangle_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rti_pkg::t_tri_in     i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rti_pkg::t_hit_out    o_out
);

    localparam int EDGE_W = rti_pkg::EDGE_W;
    localparam int CRS_W  = rti_pkg::CRS_W;
    localparam int LO_W   = rti_pkg::LO_W;
    localparam int PLO_W  = rti_pkg::PLO_W;
    localparam int PHI_W  = rti_pkg::PHI_W;
    localparam int TERM_W = rti_pkg::TERM_W;
    localparam int DOT_W  = rti_pkg::DOT_W;
    localparam int QT_W   = rti_pkg::QT_W;
    localparam int QB_W   = rti_pkg::QB_W;
    localparam int DIV_W  = rti_pkg::DIV_W;
    localparam int FB     = rti_pkg::FRAC_BITS;
    localparam int BB     = rti_pkg::BARY_BITS;

    // Ray registers.
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (rti_pkg::t_reg_idx'(i_cfg_index))
                rti_pkg::REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                rti_pkg::REG_DIR_X:    r_dir[0] <= i_cfg_data;
                rti_pkg::REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                rti_pkg::REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a result.
    logic en;
    logic r_out_vld;
    assign en = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // Valid bits of the front stages.
    logic r_vld [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < 6; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Vertices as arrays.
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];

    assign va[0] = i_in.a_x;
    assign va[1] = i_in.a_y;
    assign va[2] = i_in.a_z;
    assign vb[0] = i_in.b_x;
    assign vb[1] = i_in.b_y;
    assign vb[2] = i_in.b_z;
    assign vc[0] = i_in.c_x;
    assign vc[1] = i_in.c_y;
    assign vc[2] = i_in.c_z;

    logic signed [EDGE_W-1:0] r1_e1 [3];
    logic signed [EDGE_W-1:0] r1_e2 [3];
    logic signed [EDGE_W-1:0] r1_s  [3];
    logic signed [EDGE_W-1:0] r2_e1 [3];
    logic signed [EDGE_W-1:0] r2_e2 [3];
    logic signed [EDGE_W-1:0] r2_s  [3];
    logic signed [EDGE_W-1:0] r3_e1 [3];
    logic signed [EDGE_W-1:0] r3_e2 [3];
    logic signed [EDGE_W-1:0] r3_s  [3];
    logic signed [64:0]       r2_pa [3];
    logic signed [64:0]       r2_pb [3];
    logic signed [65:0]       r2_qa [3];
    logic signed [65:0]       r2_qb [3];
    logic signed [CRS_W-1:0]  r3_p  [3];
    logic signed [CRS_W-1:0]  r3_q  [3];
    logic signed [PLO_W-1:0]  r4_lo [3][4];
    logic signed [PHI_W-1:0]  r4_hi [3][4];
    logic signed [TERM_W-1:0] r5_term [3][4];
    logic signed [DOT_W-1:0]  r6_dot [4];

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_vec
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;

            logic signed [EDGE_W-1:0] dir_x;
            logic signed [EDGE_W-1:0] opa [4];
            logic signed [CRS_W-1:0]  opb [4];

            assign dir_x  = EDGE_W'(r_dir[k]);
            assign opa[0] = r3_e1[k];
            assign opa[1] = r3_s[k];
            assign opa[2] = dir_x;
            assign opa[3] = r3_e2[k];
            assign opb[0] = r3_p[k];
            assign opb[1] = r3_p[k];
            assign opb[2] = r3_q[k];
            assign opb[3] = r3_q[k];

            always_ff @(posedge i_clk) begin
                if (en) begin
                    // Stage 1: edges and origin offset.
                    r1_e1[k] <= EDGE_W'(vb[k]) - EDGE_W'(va[k]);
                    r1_e2[k] <= EDGE_W'(vc[k]) - EDGE_W'(va[k]);
                    r1_s[k]  <= EDGE_W'(r_org[k]) - EDGE_W'(va[k]);
                    // Stage 2: cross product terms for p = dir x e2, q = s x e1.
                    r2_pa[k] <= 65'(r_dir[K1]) * 65'(r1_e2[K2]);
                    r2_pb[k] <= 65'(r_dir[K2]) * 65'(r1_e2[K1]);
                    r2_qa[k] <= 66'(r1_s[K1]) * 66'(r1_e1[K2]);
                    r2_qb[k] <= 66'(r1_s[K2]) * 66'(r1_e1[K1]);
                    r2_e1[k] <= r1_e1[k];
                    r2_e2[k] <= r1_e2[k];
                    r2_s[k]  <= r1_s[k];
                    // Stage 3: cross product components.
                    r3_p[k]  <= CRS_W'(r2_pa[k]) - CRS_W'(r2_pb[k]);
                    r3_q[k]  <= CRS_W'(r2_qa[k]) - CRS_W'(r2_qb[k]);
                    r3_e1[k] <= r2_e1[k];
                    r3_e2[k] <= r2_e2[k];
                    r3_s[k]  <= r2_s[k];
                    // Stages 4 and 5: each dot term as two partial products.
                    for (int d = 0; d < 4; d++) begin
                        r4_lo[k][d] <= PLO_W'(opa[d])
                            * PLO_W'($signed({1'b0, opb[d][LO_W-1:0]}));
                        r4_hi[k][d] <= PHI_W'(opa[d])
                            * PHI_W'($signed(opb[d][CRS_W-1:LO_W]));
                        r5_term[k][d] <= $signed({r4_hi[k][d], {LO_W{1'b0}}})
                            + TERM_W'(r4_lo[k][d]);
                    end
                end
            end
        end
    endgenerate

    // Stage 6: det, un, vn and tn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < 4; d++) begin
                r6_dot[d] <= DOT_W'(r5_term[0][d]) + DOT_W'(r5_term[1][d])
                    + DOT_W'(r5_term[2][d]);
            end
        end
    end

    // Divider pipeline; entry 0 is stage 7 and holds the hit test.
    logic               r_dv_vld [QT_W+1];
    logic               r_dv_hit [QT_W+1];
    logic               r_dv_neg [QT_W+1];
    logic               r_dv_ovf [QT_W+1];
    logic [DOT_W-1:0]   r_dv_det [QT_W+1];
    logic [DIV_W-1:0]   r_dv_rt  [QT_W+1];
    logic [DIV_W-1:0]   r_dv_ru  [QT_W+1];
    logic [DIV_W-1:0]   r_dv_rv  [QT_W+1];
    logic [QT_W-1:0]    r_dv_qt  [QT_W+1];
    logic [QB_W-1:0]    r_dv_qu  [QT_W+1];
    logic [QB_W-1:0]    r_dv_qv  [QT_W+1];

    // Hit test and divider set-up.
    logic signed [DOT_W-1:0] det;
    logic signed [DOT_W-1:0] un;
    logic signed [DOT_W-1:0] vn;
    logic signed [DOT_W-1:0] tn;
    logic signed [DOT_W:0]   uv_sum;
    logic [DOT_W-1:0]        t_abs;
    logic                    n_hit;
    logic                    n_ovf;

    always_comb begin
        det    = r6_dot[0];
        un     = r6_dot[1];
        vn     = r6_dot[2];
        tn     = r6_dot[3];
        uv_sum = (DOT_W+1)'(un) + (DOT_W+1)'(vn);
        t_abs  = tn[DOT_W-1] ? DOT_W'(-tn) : DOT_W'(tn);
        n_hit  = (det >= rti_pkg::EPS) && !un[DOT_W-1] && !vn[DOT_W-1]
            && (un <= det) && (uv_sum <= (DOT_W+1)'(det));
        n_ovf  = ((DIV_W+1)'({t_abs, {FB{1'b0}}}))
            >= ((DIV_W+1)'(det) << QT_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_hit[0] <= n_hit;
            r_dv_neg[0] <= tn[DOT_W-1];
            r_dv_ovf[0] <= n_ovf;
            r_dv_det[0] <= det;
            r_dv_rt[0]  <= DIV_W'({t_abs, {FB{1'b0}}});
            r_dv_ru[0]  <= DIV_W'({un, {BB{1'b0}}});
            r_dv_rv[0]  <= DIV_W'({vn, {BB{1'b0}}});
            r_dv_qt[0]  <= '0;
            r_dv_qu[0]  <= '0;
            r_dv_qv[0]  <= '0;
        end
    end

    // One quotient bit per stage, most significant first.
    genvar j;
    generate
        for (j = 0; j < QT_W; j++) begin : g_div
            localparam int B = QT_W - 1 - j;

            logic [DIV_W-1:0] dsh;
            logic             t_ge;

            assign dsh  = DIV_W'(r_dv_det[j]) << B;
            assign t_ge = r_dv_rt[j] >= dsh;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[j+1] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[j+1] <= r_dv_vld[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_hit[j+1] <= r_dv_hit[j];
                    r_dv_neg[j+1] <= r_dv_neg[j];
                    r_dv_ovf[j+1] <= r_dv_ovf[j];
                    r_dv_det[j+1] <= r_dv_det[j];
                    r_dv_rt[j+1]  <= t_ge ? r_dv_rt[j] - dsh : r_dv_rt[j];
                    r_dv_qt[j+1]  <= r_dv_qt[j] | (QT_W'(t_ge) << B);
                end
            end

            if (B < QB_W) begin : g_bary
                logic u_ge;
                logic v_ge;

                assign u_ge = r_dv_ru[j] >= dsh;
                assign v_ge = r_dv_rv[j] >= dsh;

                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_ru[j+1] <= u_ge ? r_dv_ru[j] - dsh : r_dv_ru[j];
                        r_dv_rv[j+1] <= v_ge ? r_dv_rv[j] - dsh : r_dv_rv[j];
                        r_dv_qu[j+1] <= r_dv_qu[j] | (QB_W'(u_ge) << B);
                        r_dv_qv[j+1] <= r_dv_qv[j] | (QB_W'(v_ge) << B);
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_ru[j+1] <= r_dv_ru[j];
                        r_dv_rv[j+1] <= r_dv_rv[j];
                        r_dv_qu[j+1] <= r_dv_qu[j];
                        r_dv_qv[j+1] <= r_dv_qv[j];
                    end
                end
            end
        end
    endgenerate

    // Sign, saturation and miss masking of the final result.
    rti_pkg::t_hit_out n_out;
    rti_pkg::t_hit_out r_out;
    logic [QT_W-1:0]   qt;

    always_comb begin
        qt    = r_dv_qt[QT_W];
        n_out = '0;
        if (r_dv_hit[QT_W]) begin
            n_out.hit    = 1'b1;
            n_out.bary_u = r_dv_qu[QT_W];
            n_out.bary_v = r_dv_qv[QT_W];
            if (!r_dv_neg[QT_W]) begin
                if (r_dv_ovf[QT_W] || qt > QT_W'(32'h7FFF_FFFF)) begin
                    n_out.dist_t = 32'sh7FFF_FFFF;
                end else begin
                    n_out.dist_t = qt[31:0];
                end
            end else begin
                if (r_dv_ovf[QT_W] || qt > QT_W'(32'h8000_0000)) begin
                    n_out.dist_t = 32'sh8000_0000;
                end else begin
                    n_out.dist_t = 32'(32'd0 - qt[31:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[QT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ray_triangle_intersect pipeline.
// Depends on rti_pkg and ray_triangle_intersect; a wide-integer predictor checks every result.
`timescale 1ns / 1ps

module tb;

    localparam int  CLK_HALF    = 6;
    localparam int  PIPE_LAT    = 41;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 950;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    rti_pkg::t_tri_in   i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    rti_pkg::t_hit_out  o_out;

    // Shadow copy of the ray registers.
    logic signed [31:0] ray_reg [6];

    rti_pkg::t_hit_out hit_queue [$];
    int                fail_count;
    int                cycle_count;
    bit                idle_enable;

    ray_triangle_intersect u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Exact intersection math at 160 bits, which holds every product unwrapped.
    function automatic rti_pkg::t_hit_out predict_hit(rti_pkg::t_tri_in tri_item);
        logic signed [159:0] ox, oy, oz, dx, dy, dz;
        logic signed [159:0] e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
        logic signed [159:0] px, py, pz, qx, qy, qz;
        logic signed [159:0] det, un, vn, tn, eps, tq;
        rti_pkg::t_hit_out res;
        ox = ray_reg[rti_pkg::REG_ORIGIN_X];
        oy = ray_reg[rti_pkg::REG_ORIGIN_Y];
        oz = ray_reg[rti_pkg::REG_ORIGIN_Z];
        dx = ray_reg[rti_pkg::REG_DIR_X];
        dy = ray_reg[rti_pkg::REG_DIR_Y];
        dz = ray_reg[rti_pkg::REG_DIR_Z];
        e1x = 160'(tri_item.b_x) - 160'(tri_item.a_x);
        e1y = 160'(tri_item.b_y) - 160'(tri_item.a_y);
        e1z = 160'(tri_item.b_z) - 160'(tri_item.a_z);
        e2x = 160'(tri_item.c_x) - 160'(tri_item.a_x);
        e2y = 160'(tri_item.c_y) - 160'(tri_item.a_y);
        e2z = 160'(tri_item.c_z) - 160'(tri_item.a_z);
        sx  = ox - 160'(tri_item.a_x);
        sy  = oy - 160'(tri_item.a_y);
        sz  = oz - 160'(tri_item.a_z);
        res = '0;
        eps = ((160'sd1 <<< (3 * rti_pkg::FRAC_BITS)) + 160'sd5000) / 160'sd10000;
        px = dy * e2z - dz * e2y;
        py = dz * e2x - dx * e2z;
        pz = dx * e2y - dy * e2x;
        det = e1x * px + e1y * py + e1z * pz;
        if (det < eps) return res;
        un = sx * px + sy * py + sz * pz;
        if (un < 0 || det < un) return res;
        qx = sy * e1z - sz * e1y;
        qy = sz * e1x - sx * e1z;
        qz = sx * e1y - sy * e1x;
        vn = dx * qx + dy * qy + dz * qz;
        if (vn < 0 || det < un + vn) return res;
        tn = e2x * qx + e2y * qy + e2z * qz;
        // Signed division truncates toward zero; det is positive here.
        tq = (tn <<< rti_pkg::FRAC_BITS) / det;
        if (tq > 160'sd2147483647) tq = 160'sd2147483647;
        if (tq < -160'sd2147483648) tq = -160'sd2147483648;
        res.hit    = 1'b1;
        res.dist_t = tq[31:0];
        res.bary_u = 17'((un <<< rti_pkg::BARY_BITS) / det);
        res.bary_v = 17'((vn <<< rti_pkg::BARY_BITS) / det);
        return res;
    endfunction

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver backpressure, changed at the falling edge.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= idle_enable ? ($urandom_range(99) >= 24) : 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        rti_pkg::t_hit_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hit_queue.size() == 0) begin
                $error("result with no expectation: %h", o_out);
                fail_count++;
            end else begin
                want = hit_queue.pop_front();
                if (o_out.hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, o_out.hit);
                    fail_count++;
                end
                if (o_out.dist_t !== want.dist_t) begin
                    $error("dist_t: expected %0d actual %0d", want.dist_t, o_out.dist_t);
                    fail_count++;
                end
                if (o_out.bary_u !== want.bary_u) begin
                    $error("bary_u: expected %0d actual %0d", want.bary_u, o_out.bary_u);
                    fail_count++;
                end
                if (o_out.bary_v !== want.bary_v) begin
                    $error("bary_v: expected %0d actual %0d", want.bary_v, o_out.bary_v);
                    fail_count++;
                end
            end
        end
    end

    // Send one triangle request, with an optional random gap ahead of it.
    task automatic send_triangle(rti_pkg::t_tri_in tri_item);
        while (idle_enable && $urandom_range(99) < 24) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in       = tri_item;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        hit_queue = {hit_queue, predict_hit(tri_item)};
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Wait until all results are back and the pipeline is empty.
    task automatic drain_pipe();
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(rti_pkg::t_reg_idx idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        ray_reg[idx] = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        drain_pipe();
        write_reg(rti_pkg::REG_ORIGIN_X, ox);
        write_reg(rti_pkg::REG_ORIGIN_Y, oy);
        write_reg(rti_pkg::REG_ORIGIN_Z, oz);
        write_reg(rti_pkg::REG_DIR_X, dx);
        write_reg(rti_pkg::REG_DIR_Y, dy);
        write_reg(rti_pkg::REG_DIR_Z, dz);
    endtask

    function automatic rti_pkg::t_tri_in make_tri(int ax, int ay, int az,
                                                  int bx, int by, int bz,
                                                  int cx, int cy, int cz);
        rti_pkg::t_tri_in t;
        t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    function automatic rti_pkg::t_tri_in noise_tri();
        rti_pkg::t_tri_in t;
        t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        return t;
    endfunction

    // Triangle placed around a point on the current ray, random winding.
    function automatic rti_pkg::t_tri_in aimed_tri(int span);
        int k, cx, cy, cz;
        int vx [3], vy [3], vz [3];
        rti_pkg::t_tri_in t;
        k  = $urandom_range(8) - 2;
        cx = ray_reg[rti_pkg::REG_ORIGIN_X] + k * ray_reg[rti_pkg::REG_DIR_X];
        cy = ray_reg[rti_pkg::REG_ORIGIN_Y] + k * ray_reg[rti_pkg::REG_DIR_Y];
        cz = ray_reg[rti_pkg::REG_ORIGIN_Z] + k * ray_reg[rti_pkg::REG_DIR_Z];
        for (int i = 0; i < 3; i++) begin
            vx[i] = cx + $signed($urandom_range(2 * span)) - span;
            vy[i] = cy + $signed($urandom_range(2 * span)) - span;
            vz[i] = cz + $signed($urandom_range(2 * span)) - span;
        end
        t = make_tri(vx[0], vy[0], vz[0], vx[1], vy[1], vz[1], vx[2], vy[2], vz[2]);
        return t;
    endfunction

    // Hand-picked triangles: front and back faces, edges, extremes.
    task automatic test_directed();
        localparam int ONE = 65536;
        set_ray(0, 0, -5 * ONE, 0, 0, ONE);
        // Front face straight ahead.
        send_triangle(make_tri(-ONE, -ONE, 0, -ONE, ONE, 0, ONE, -ONE, 0));
        // Same triangle seen from behind.
        send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0));
        // Ray passes outside in u, then outside in both u and v, then through an edge midpoint.
        send_triangle(make_tri(ONE, ONE, 0, ONE, 3 * ONE, 0, 3 * ONE, ONE, 0));
        send_triangle(make_tri(-3 * ONE, ONE, 0, -3 * ONE, 3 * ONE, 0, -ONE, ONE, 0));
        send_triangle(make_tri(ONE, -ONE, 0, -ONE, ONE, 0, ONE, ONE, 0));
        // Ray on a vertex and on an edge.
        send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_triangle(make_tri(0, -ONE, 0, 0, ONE, 0, ONE, 0, 0));
        // Triangle behind the origin, negative t.
        send_triangle(make_tri(-ONE, -ONE, -9 * ONE, -ONE, ONE, -9 * ONE,
                               ONE, -ONE, -9 * ONE));
        // Parallel to the ray and degenerate.
        send_triangle(make_tri(0, -ONE, 0, 0, ONE, 0, 0, 0, ONE));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Field extremes.
        send_triangle(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff));
        send_triangle(make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000));
        send_triangle(make_tri(32'h80000000, 32'h80000000, 0, 32'h80000000,
                               32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0));
        // Tiny direction, far origin: t saturates high, then low.
        set_ray(0, 0, 32'h80000000, 0, 0, 1);
        send_triangle(make_tri(32'hc0000000, 32'hc0000000, 32'h7fffffff, 32'hc0000000,
                               32'h40000000, 32'h7fffffff, 32'h40000000, 32'hc0000000,
                               32'h7fffffff));
        set_ray(0, 0, 32'h7fffffff, 0, 0, 1);
        send_triangle(make_tri(32'hc0000000, 32'hc0000000, 32'h80000000, 32'hc0000000,
                               32'h40000000, 32'h80000000, 32'h40000000, 32'hc0000000,
                               32'h80000000));
        // Zero direction always misses.
        set_ray(0, 0, 0, 0, 0, 0);
        send_triangle(make_tri(-ONE, -ONE, 0, -ONE, ONE, 0, ONE, -ONE, 0));
    endtask

    // Mostly triangles aimed at a random ray, the rest full-range noise.
    task automatic test_random_rays(int n_items);
        int span;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0)
                set_ray($signed($urandom_range(1 << 22)) - (1 << 21),
                        $signed($urandom_range(1 << 22)) - (1 << 21),
                        $signed($urandom_range(1 << 22)) - (1 << 21),
                        $signed($urandom_range(1 << 18)) - (1 << 17),
                        $signed($urandom_range(1 << 18)) - (1 << 17),
                        $signed($urandom_range(1 << 18)) - (1 << 17));
            // One stretch with no idling at all.
            idle_enable = !(i >= 300 && i < 450);
            span = ($urandom_range(3) == 0) ? (1 << 24) : (1 << 19);
            if ($urandom_range(99) < 80) send_triangle(aimed_tri(span));
            else send_triangle(noise_tri());
        end
        idle_enable = 1'b1;
    endtask

    // Rays at the register extremes and fully random.
    task automatic test_extreme_rays();
        set_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        repeat (10) send_triangle(noise_tri());
        repeat (10) send_triangle(aimed_tri(1 << 28));
        set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000);
        repeat (10) send_triangle(noise_tri());
        repeat (10) send_triangle(aimed_tri(1 << 28));
        set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        repeat (20) send_triangle(noise_tri());
        repeat (20) send_triangle(aimed_tri(1 << 26));
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        for (int i = 0; i < 6; i++) ray_reg[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_rays(N_RANDOM - 100);
        test_extreme_rays();
        drain_pipe();

        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
